@@ src/b64enc_pkg.sv @@
`default_nettype none

package b64enc_pkg;

   // queue between the byte front end and the character back end
   localparam int QUEUE_DEPTH = 2;

   localparam int CHAR_W    = 7;
   localparam int SEXTET_W  = 6;
   localparam int SLOT_NUM  = 4;
   localparam int SLOT_IDX_W = 2;

   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

   // characters that one byte produces, ready to be sent in order
   typedef struct packed {
      logic [SLOT_NUM-1:0][CHAR_W-1:0] chars;
      logic [SLOT_IDX_W-1:0]           last_idx;
      logic                            eot;
   } group_entry_type;

   // standard base64 alphabet lookup
   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] ch;
      if (v < 6'd26) begin
         ch = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         ch = 7'h61 + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 7'h30 + {1'b0, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ src/b64enc_front.sv @@
`default_nettype none

module b64enc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        take,
   input  wire logic [7:0]                  data_byte,
   input  wire logic                        is_final,
   output b64enc_pkg::group_entry_type      entry
);
   import b64enc_pkg::*;

   typedef enum logic [1:0] {
      PH_0 = 2'd0,
      PH_1 = 2'd1,
      PH_2 = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;

   // split the byte into sextets against the leftover bits
   always_comb begin
      entry          = '0;
      entry.chars[2] = PAD_CHAR;
      entry.chars[3] = PAD_CHAR;
      phase_in       = phase_ff;
      carry_in       = carry_ff;
      unique case (phase_ff)
         PH_1: begin
            entry.chars[0] = sextet_char({carry_ff[1:0], data_byte[7:4]});
            entry.chars[1] = sextet_char({data_byte[3:0], 2'b00});
            if (is_final) begin
               entry.last_idx = 2'd2;
               entry.eot      = 1'b1;
               phase_in       = PH_0;
               carry_in       = '0;
            end else begin
               entry.last_idx = 2'd0;
               phase_in       = PH_2;
               carry_in       = data_byte[3:0];
            end
         end
         PH_2: begin
            entry.chars[0] = sextet_char({carry_ff, data_byte[7:6]});
            entry.chars[1] = sextet_char(data_byte[5:0]);
            entry.last_idx = 2'd1;
            entry.eot      = is_final;
            phase_in       = PH_0;
            carry_in       = '0;
         end
         default: begin
            entry.chars[0] = sextet_char(data_byte[7:2]);
            entry.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
            if (is_final) begin
               entry.last_idx = 2'd3;
               entry.eot      = 1'b1;
               phase_in       = PH_0;
               carry_in       = '0;
            end else begin
               entry.last_idx = 2'd0;
               phase_in       = PH_1;
               carry_in       = {2'b00, data_byte[1:0]};
            end
         end
      endcase
   end

   // group phase and leftover bits
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         carry_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

   a_carry_clear_ph0: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_0 |-> carry_ff == 4'd0)
      else $error("leftover bits not clear at group start");

   a_carry_narrow_ph1: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_1 |-> carry_ff[3:2] == 2'd0)
      else $error("more than two leftover bits after first byte");

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      take && is_final |=> phase_ff == PH_0)
      else $error("final byte did not restart the group");

endmodule

`default_nettype wire

@@ src/b64enc_queue.sv @@
`default_nettype none

module b64enc_queue #(
   parameter int Depth = b64enc_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire b64enc_pkg::group_entry_type push_entry,
   output logic                             full,
   input  wire logic                        pop,
   output b64enc_pkg::group_entry_type      head_entry,
   output logic                             head_valid
);
   import b64enc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr   = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(Depth);

   group_entry_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full       = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("item pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ src/b64enc_back.sv @@
`default_nettype none

module b64enc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire b64enc_pkg::group_entry_type head_entry,
   input  wire logic                        head_valid,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [b64enc_pkg::CHAR_W-1:0]    code_char,
   output logic                             end_of_text
);
   import b64enc_pkg::*;

   group_entry_type        cur_ff;
   logic                   cur_valid_ff, cur_valid_in;
   logic [SLOT_IDX_W-1:0]  idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   out_free, issue, cur_done;

   // one character per cycle from the current entry while the output is not stalled
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign issue    = out_free && cur_valid_ff;
   assign cur_done = issue && (idx_ff == cur_ff.last_idx);
   assign pop      = head_valid && (!cur_valid_ff || cur_done);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         char_in      = cur_ff.chars[idx_ff];
         last_in      = cur_ff.eot && cur_done;
         idx_in       = idx_ff + 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (cur_done) begin
         cur_valid_in = 1'b0;
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
      if (pop) begin
         cur_ff <= head_entry;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign code_char   = char_ff;
   assign end_of_text = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= cur_ff.last_idx)
      else $error("character index past end of entry");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      head_valid && !cur_valid_ff |-> pop)
      else $error("back end idle while queue holds an entry");

   // first cycle out of reset starts empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid_ff && !cur_valid_ff)
      else $error("output not empty after reset");

endmodule

`default_nettype wire

@@ src/base64_stream_encoder.sv @@
`default_nettype none

// channel   direction  tdata                          tlast
// req_      in         [7:0] data_byte                is_final
// rsp_      out        [6:0] code_char, [7] zero      end_of_text
//
// a byte is split into characters in the cycle it is accepted and parked in a
// small entry queue; the back end sends one character per cycle unless the output
// stalls, so a byte yields one to four characters (four characters per three bytes,
// up to four on a final byte), going from queue slot to current entry to output register.
// reset is synchronous and clears group phase, queue and output register.
// req_tready drops only when the queue is full; output stalls back up into it.
module base64_stream_encoder #(
   parameter int QueueDepth = b64enc_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] code_char, [7] zero
   output logic            rsp_tlast
);
   import b64enc_pkg::*;

   group_entry_type   new_entry, head_entry;
   logic              take, full, pop, head_valid;
   logic [CHAR_W-1:0] code_char;

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   b64enc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .is_final  (req_tlast),
      .entry     (new_entry)
   );

   b64enc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_entry (new_entry),
      .full       (full),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid)
   );

   b64enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .code_char   (code_char),
      .end_of_text (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, code_char};

endmodule

`default_nettype wire

@@ tb/sv/tb_base64_stream_encoder.sv @@
`timescale 1ns / 100ps

module tb_base64_stream_encoder;
   import b64enc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   // position of the next byte inside its three-byte group
   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2
   } group_pos_type;

   // one encoded character as the output channel carries it
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              eot;
   } code_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // is_final
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] code_char, [7] zero
   logic       rsp_tlast;           // end_of_text

   string      b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   group_pos_type enc_pos;
   logic [3:0]    enc_carry;
   code_item_type pending_chars[$];
   code_item_type want;
   int            quiet_cycles;
   int            send_gap_pct;
   int            recv_gap_pct;
   int            hold_left;
   bit            failed;

   base64_stream_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // sextet to alphabet character
   function automatic logic [CHAR_W-1:0] sextet_symbol(input logic [5:0] v);
      byte c;
      c = b64_alphabet[v];
      return c[CHAR_W-1:0];
   endfunction

   function automatic void push_char(input logic [CHAR_W-1:0] code, input logic eot);
      code_item_type item;
      item.code = code;
      item.eot  = eot;
      pending_chars.push_back(item);
   endfunction

   // expected characters of one accepted byte, advancing the group position
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      case (enc_pos)
         POS_SECOND: begin
            push_char(sextet_symbol({enc_carry[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               push_char(sextet_symbol({b[3:0], 2'b00}), 1'b0);
               push_char(PAD_CHAR, 1'b1);
               enc_pos   = POS_FIRST;
               enc_carry = 4'h0;
            end else begin
               enc_pos   = POS_THIRD;
               enc_carry = b[3:0];
            end
         end
         POS_THIRD: begin
            push_char(sextet_symbol({enc_carry, b[7:6]}), 1'b0);
            push_char(sextet_symbol(b[5:0]), fin);
            enc_pos   = POS_FIRST;
            enc_carry = 4'h0;
         end
         default: begin
            push_char(sextet_symbol(b[7:2]), 1'b0);
            if (fin) begin
               push_char(sextet_symbol({b[1:0], 4'h0}), 1'b0);
               push_char(PAD_CHAR, 1'b0);
               push_char(PAD_CHAR, 1'b1);
               enc_pos   = POS_FIRST;
               enc_carry = 4'h0;
            end else begin
               enc_pos   = POS_SECOND;
               enc_carry = {2'b00, b[1:0]};
            end
         end
      endcase
   endfunction

   // both handshakes seen at the rising edge: predict, check, watchdog
   always @(posedge clock) begin
      if (reset) begin
         enc_pos      = POS_FIRST;
         enc_carry    = 4'h0;
         quiet_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               $display("%0t: no item expected, got char %h eot %b",
                        $time, rsp_tdata[CHAR_W-1:0], rsp_tlast);
               failed = 1'b1;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.code) begin
                  $display("%0t: code_char expected %h, actual %h",
                           $time, want.code, rsp_tdata[CHAR_W-1:0]);
                  failed = 1'b1;
               end
               if (rsp_tlast !== want.eot) begin
                  $display("%0t: end_of_text expected %b, actual %b",
                           $time, want.eot, rsp_tlast);
                  failed = 1'b1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("base64_stream_encoder: mismatch");
            $finish;
         end
      end
   end

   // receiver: random stalls, or a long hold-off counted here
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // offer one item, keeping valid high across back-to-back items
   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and let every expected character come out
   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // short messages hitting final bytes in every group position
   task automatic test_directed();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // sextets of 62, the plus sign
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      // final byte right after a full group
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hAA, 1'b1);
   endtask

   // messages of random length and content, the last byte marked final
   task automatic test_random_messages(input int count);
      int left;
      int len;
      logic [7:0] b;
      left = count;
      while (left > 0) begin
         len = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 30);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
               0: b = 8'h00;
               1: b = 8'hFF;
               default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == len - 1);
         end
         left = left - len;
      end
   endtask

   // receiver holds off while bytes keep coming, so the input stalls
   task automatic test_output_stall();
      hold_left = HOLD_CYCLES;
      test_random_messages(16);
      wait_drain();
   endtask

   // sender pauses mid-message until everything is out, then finishes it
   task automatic test_pause_mid_message();
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0);
      wait_drain();
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b1);
   endtask

   // test sequence
   initial begin
      failed       = 1'b0;
      hold_left    = 0;
      send_gap_pct = 30;
      recv_gap_pct = 61;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_messages(85);
      test_output_stall();

      send_gap_pct = 61;
      recv_gap_pct = 30;
      test_random_messages(85);
      test_pause_mid_message();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      test_random_messages(85);

      wait_drain();
      repeat (10) @(posedge clock);
      if (!failed) begin
         $display("base64_stream_encoder: match");
      end else begin
         $display("base64_stream_encoder: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder.sv
tb/sv/tb_base64_stream_encoder.sv
